/* rtl/core/pfrp_pkg.sv */
// shared constants, codes and transfer types of the page frame replacement policy core
`timescale 1ns / 1ps

package pfrp_pkg;

    localparam int NUM_FRAMES = 1024;
    localparam int FRAME_W    = 10;
    localparam int FRAME_IDS  = 1 << FRAME_W;
    localparam int AGE_W      = 8;
    localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_SELECT = 2'd2
    } t_op;

    typedef enum logic {
        POL_CLOCK = 1'b0,
        POL_AGING = 1'b1
    } t_policy;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [FRAME_W-1:0] frame_number;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0] victim_frame;
        logic               victim_found;
    } t_out_item;

    // accepted operation handed to the engine
    typedef struct packed {
        logic               valid;
        t_op                op;
        logic [FRAME_W-1:0] frame;
        t_policy            policy;
    } t_eng_req;

    // engine status back to the top level
    typedef struct packed {
        logic      idle;
        logic      res_valid;
        t_out_item res;
    } t_eng_rsp;

endpackage

/* rtl/core/pfrp_ram.sv */
// generic simple dual-port synchronous ram with registered read data
`timescale 1ns / 1ps

module pfrp_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/pfrp_engine.sv */
// replacement engine: frame fifo, access bit and age memories with the walk pipeline
`timescale 1ns / 1ps

module pfrp_engine import pfrp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_eng_req i_req,
    input  logic     i_res_take,
    output t_eng_rsp o_rsp
);

    // control state
    t_state             r_state, n_state;
    logic [FRAME_W-1:0] r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_hand, n_hand;
    logic [CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic               r_s1_vld, n_s1_vld;
    logic               r_s2_vld, n_s2_vld;
    logic               r_s3_vld, n_s3_vld;

    // payload state
    logic [FRAME_W-1:0] r_head, n_head;
    t_policy            r_mode, n_mode;
    logic [CNT_W-1:0]   r_s1_idx, n_s1_idx;
    logic [CNT_W-1:0]   r_s2_idx, n_s2_idx;
    logic [FRAME_W-1:0] r_s2_frame, n_s2_frame;
    logic [FRAME_W-1:0] r_s3_frame, n_s3_frame;
    logic [AGE_W-1:0]   r_s3_age, n_s3_age;
    logic [AGE_W-1:0]   r_best, n_best;
    t_out_item          r_res, n_res;

    // memory ports
    logic               fifo_we;
    logic [IDX_W-1:0]   fifo_waddr, fifo_raddr;
    logic [FRAME_W-1:0] fifo_rdata;
    logic               acc_we, acc_wdata, acc_rdata;
    logic [FRAME_W-1:0] acc_waddr;
    logic               age_we;
    logic [FRAME_W-1:0] age_waddr;
    logic [AGE_W-1:0]   age_wdata, age_rdata;

    // evaluation stage
    logic               fwd;
    logic               eff_acc;
    logic [AGE_W-1:0]   eff_age;
    logic [AGE_W-1:0]   new_age;
    logic [CNT_W-1:0]   s2_next;
    logic               s2_last;

    pfrp_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_FRAMES)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (i_req.frame),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    pfrp_ram #(.WIDTH(1), .DEPTH(FRAME_IDS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (fifo_rdata),
        .o_rdata (acc_rdata)
    );

    pfrp_ram #(.WIDTH(AGE_W), .DEPTH(FRAME_IDS)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (age_waddr),
        .i_wdata (age_wdata),
        .i_raddr (fifo_rdata),
        .o_rdata (age_rdata)
    );

    assign fifo_waddr = r_count[IDX_W-1:0];
    assign fifo_raddr = r_rd_idx[IDX_W-1:0];

    // the entry evaluated last cycle was written back after this read was issued
    assign fwd     = r_s3_vld && (r_s3_frame == r_s2_frame);
    assign eff_acc = (fwd && (r_mode == POL_CLOCK)) ? 1'b0 : acc_rdata;
    assign eff_age = fwd ? r_s3_age : age_rdata;
    assign new_age = {eff_acc, eff_age[AGE_W-1:1]};
    assign s2_next = r_s2_idx + CNT_W'(1);
    assign s2_last = (s2_next == r_count);

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_count    = r_count;
        n_hand     = r_hand;
        n_rd_idx   = r_rd_idx;
        n_s1_vld   = 1'b0;
        n_s2_vld   = 1'b0;
        n_s3_vld   = 1'b0;
        n_head     = r_head;
        n_mode     = r_mode;
        n_s1_idx   = r_s1_idx;
        n_s2_idx   = r_s1_idx;
        n_s2_frame = fifo_rdata;
        n_s3_frame = r_s2_frame;
        n_s3_age   = new_age;
        n_best     = r_best;
        n_res      = r_res;
        fifo_we    = 1'b0;
        acc_we     = 1'b0;
        acc_waddr  = i_req.frame;
        acc_wdata  = 1'b1;
        age_we     = 1'b0;
        age_waddr  = r_clr_idx;
        age_wdata  = '0;

        unique case (r_state)
            ST_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = r_clr_idx;
                acc_wdata = 1'b0;
                age_we    = 1'b1;
                n_clr_idx = r_clr_idx + FRAME_W'(1);
                if (r_clr_idx == '1) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_req.valid) begin
                    unique case (i_req.op)
                        OP_INSERT: begin
                            if (r_count < CNT_W'(NUM_FRAMES)) begin
                                fifo_we = 1'b1;
                                n_count = r_count + CNT_W'(1);
                                if (r_count == '0) begin
                                    n_head = i_req.frame;
                                end
                            end
                        end
                        OP_TOUCH: begin
                            acc_we = 1'b1;
                        end
                        OP_SELECT: begin
                            n_mode = i_req.policy;
                            n_best = '1;
                            n_res  = '0;
                            if (r_count == '0) begin
                                n_state = ST_RESULT;
                            end else if ((i_req.policy == POL_CLOCK) && (r_hand >= r_count)) begin
                                n_res   = '{victim_frame: r_head, victim_found: 1'b1};
                                n_hand  = CNT_W'(1);
                                n_state = ST_RESULT;
                            end else begin
                                n_rd_idx = (i_req.policy == POL_CLOCK) ? r_hand : '0;
                                n_state  = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_WALK: begin
                // issue fifo reads one entry per cycle
                if (r_rd_idx < r_count) begin
                    n_s1_vld = 1'b1;
                    n_s1_idx = r_rd_idx;
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                end
                n_s2_vld = r_s1_vld;
                n_s3_vld = r_s2_vld;

                if (r_s2_vld) begin
                    if (r_mode == POL_CLOCK) begin
                        if (eff_acc) begin
                            // second chance: clear and go on
                            acc_we    = 1'b1;
                            acc_waddr = r_s2_frame;
                            acc_wdata = 1'b0;
                            if (s2_last) begin
                                n_res   = '{victim_frame: r_head, victim_found: 1'b1};
                                n_hand  = CNT_W'(1);
                                n_state = ST_RESULT;
                            end
                        end else begin
                            n_res = '{victim_frame: r_s2_frame, victim_found: 1'b1};
                            if (!s2_last) begin
                                n_hand = s2_next;
                            end
                            n_state = ST_RESULT;
                        end
                    end else begin
                        age_we    = 1'b1;
                        age_waddr = r_s2_frame;
                        age_wdata = new_age;
                        if (new_age < r_best) begin
                            n_best = new_age;
                            n_res  = '{victim_frame: r_s2_frame, victim_found: 1'b1};
                        end
                        if (s2_last) begin
                            n_state = ST_RESULT;
                        end
                    end
                end
            end

            ST_RESULT: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_count   <= '0;
            r_hand    <= '0;
            r_rd_idx  <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_count   <= n_count;
            r_hand    <= n_hand;
            r_rd_idx  <= n_rd_idx;
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= n_s2_vld;
            r_s3_vld  <= n_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_mode     <= n_mode;
        r_s1_idx   <= n_s1_idx;
        r_s2_idx   <= n_s2_idx;
        r_s2_frame <= n_s2_frame;
        r_s3_frame <= n_s3_frame;
        r_s3_age   <= n_s3_age;
        r_best     <= n_best;
        r_res      <= n_res;
    end

    assign o_rsp = '{
        idle:      (r_state == ST_IDLE),
        res_valid: (r_state == ST_RESULT),
        res:       r_res
    };

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_req.valid && i_req.op == OP_INSERT
         && r_count < CNT_W'(NUM_FRAMES))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance the fifo count");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && !i_res_take) |=> (r_state == ST_RESULT && $stable(r_res)))
        else $error("result lost before transfer");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hand <= r_count) || (r_hand == CNT_W'(1)))
        else $error("clock hand beyond tail");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s2_vld) |-> (r_s1_idx == r_s2_idx + CNT_W'(1)))
        else $error("walk pipeline out of order");

endmodule

/* rtl/core/page_frame_replacement_policy_core.sv */
// top level of the page frame replacement policy core: handshakes, policy register, result register
`timescale 1ns / 1ps
// insert and touch complete without leaving idle; one such transfer can be accepted every cycle while idle
// select: the walk reads one entry per cycle through the fifo memory then the access/age memories;
// it is skipped when the fifo is empty or the clock hand already sits at the tail; input stalls
// from the accepted select until its result has been taken by the result register
// after reset a pass clears access bits and ages of all 1024 frame ids; input stalls meanwhile
// policy register resets to second chance clock; reset is synchronous, active low

module page_frame_replacement_policy_core import pfrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input item channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    // policy register write channel
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    t_policy   r_policy;
    logic      r_out_valid;
    t_out_item r_out;

    t_eng_req  eng_req;
    t_eng_rsp  eng_rsp;
    logic      in_xfer;
    logic      out_free;
    logic      res_take;

    // items are only taken while the engine sits idle
    assign o_in_stall = !eng_rsp.idle;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign eng_req = '{
        valid:  in_xfer,
        op:     i_in_data.operation,
        frame:  i_in_data.frame_number,
        policy: r_policy
    };

    // result register frees up in the same cycle its transfer completes
    assign out_free = !r_out_valid || !i_out_stall;
    assign res_take = eng_rsp.res_valid && out_free;

    pfrp_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (eng_req),
        .i_res_take (res_take),
        .o_rsp      (eng_rsp)
    );

    // policy register; the user must write it only between operations, the block itself does not enforce this
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_CLOCK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= t_policy'(i_cfg_data);
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= eng_rsp.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
